// File: design/bhf_pkg.sv
// Package: shared types and constants of the backend health failover block.
`timescale 1ns / 1ps
package bhf_pkg;

    localparam int MAX_BACKENDS = 16;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = IDX_W + 1;
    localparam int STREAK_W     = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_UP_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKEND_COUNT  = 2'd2;

    localparam logic [STREAK_W-1:0] UP_THRESHOLD_RST   = 8'd2;
    localparam logic [STREAK_W-1:0] DOWN_THRESHOLD_RST = 8'd3;
    localparam logic [CNT_W-1:0]    BACKEND_COUNT_RST  = 5'd16;

    typedef enum logic [1:0] {
        TR_NONE = 2'd0,
        TR_UP   = 2'd1,
        TR_DOWN = 2'd2
    } t_trans;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] backend_index;
        logic             probe_passed;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] reported_backend;
        t_trans           transition;
        logic             now_healthy;
        logic [IDX_W-1:0] map_target;
        logic             map_target_valid;
    } t_out;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] target;
    } t_scan_res;

endpackage

// File: design/bhf_scan.sv
// Sequential search for the lowest-numbered healthy backend other than one excluded index.
`timescale 1ns / 1ps
module bhf_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bhf_pkg::MAX_BACKENDS-1:0] i_flags,
    input  logic [bhf_pkg::CNT_W-1:0]      i_count,
    input  logic [bhf_pkg::IDX_W-1:0]      i_skip,
    output bhf_pkg::t_scan_res             o_res
);
    import bhf_pkg::*;

    logic             r_busy;
    logic [IDX_W-1:0] r_pos;
    logic             w_hit;
    logic             w_last;
    logic [CNT_W-1:0] w_pos_next;

    assign w_pos_next = {1'b0, r_pos} + CNT_W'(1);
    assign w_hit      = i_flags[r_pos] && (r_pos != i_skip);
    assign w_last     = (w_pos_next >= i_count);

    assign o_res.done   = r_busy && (w_hit || w_last);
    assign o_res.found  = r_busy && w_hit;
    assign o_res.target = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (r_busy) begin
            if (w_hit || w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_pos <= w_pos_next[IDX_W-1:0];
            end
        end
    end

endmodule

// File: design/backend_health_hysteresis_failover.sv
// Top level: per-backend probe hysteresis with failover target selection.
`timescale 1ns / 1ps
// Each input beat is one probe outcome for one backend; each produces exactly one result
// beat. A beat is taken only while the block is idle. A probe that causes no takedown
// keeps the block busy through the take, update and emit steps, and its result beat is
// presented from the output register once the emit step has run. A takedown walks the
// healthy flags one backend per cycle in the search unit, which adds a scan step between
// update and emit. The emit step waits while an earlier result beat is still stalled at
// the output; once the result register is loaded, the next probe can be taken while that
// beat waits. The configuration port is always ready.
module backend_health_hysteresis_failover (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bhf_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bhf_pkg::t_out                  o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bhf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bhf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bhf_pkg::*;

    t_state                  r_state, n_state;
    t_in                     r_item;
    t_out                    r_res, n_res;
    t_out                    r_out;
    logic                    r_out_valid;
    logic [STREAK_W-1:0]     r_up_thr, r_down_thr;
    logic [CNT_W-1:0]        r_count;
    logic [STREAK_W-1:0]     r_pass [MAX_BACKENDS];
    logic [STREAK_W-1:0]     r_fail [MAX_BACKENDS];
    logic [MAX_BACKENDS-1:0] r_flags;

    logic [CNT_W-1:0]        w_in_use;
    logic                    w_active;
    logic [STREAK_W-1:0]     w_pass_cur, w_fail_cur;
    logic [STREAK_W-1:0]     n_pass, n_fail;
    logic                    n_flag;
    logic                    w_update;
    logic                    w_scan_start;
    logic                    w_load_out;
    t_scan_res               w_scan;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_in_use   = (r_count > CNT_W'(MAX_BACKENDS)) ? CNT_W'(MAX_BACKENDS) : r_count;
    assign w_active   = ({1'b0, r_item.backend_index} < w_in_use);
    assign w_pass_cur = r_pass[r_item.backend_index];
    assign w_fail_cur = r_fail[r_item.backend_index];

    always_comb begin
        n_pass = '0;
        n_fail = '0;
        n_flag = r_flags[r_item.backend_index];
        if (r_item.probe_passed) begin
            n_pass = (w_pass_cur == STREAK_MAX) ? w_pass_cur : w_pass_cur + STREAK_W'(1);
            if (!n_flag && n_pass >= r_up_thr) begin
                n_flag = 1'b1;
            end
        end else begin
            n_fail = (w_fail_cur == STREAK_MAX) ? w_fail_cur : w_fail_cur + STREAK_W'(1);
            if (n_flag && n_fail >= r_down_thr) begin
                n_flag = 1'b0;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        w_update     = 1'b0;
        w_scan_start = 1'b0;
        w_load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_res.reported_backend = r_item.backend_index;
                n_res.transition       = TR_NONE;
                n_res.now_healthy      = r_flags[r_item.backend_index];
                n_res.map_target       = '0;
                n_res.map_target_valid = 1'b0;
                n_state                = ST_EMIT;
                if (w_active) begin
                    w_update          = 1'b1;
                    n_res.now_healthy = n_flag;
                    if (n_flag && !r_flags[r_item.backend_index]) begin
                        n_res.transition       = TR_UP;
                        n_res.map_target       = r_item.backend_index;
                        n_res.map_target_valid = 1'b1;
                    end else if (!n_flag && r_flags[r_item.backend_index]) begin
                        n_res.transition = TR_DOWN;
                        w_scan_start     = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_scan.done) begin
                    n_res.map_target       = w_scan.found ? w_scan.target : '0;
                    n_res.map_target_valid = w_scan.found;
                    n_state                = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    bhf_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scan_start),
        .i_flags (r_flags),
        .i_count (w_in_use),
        .i_skip  (r_item.backend_index),
        .o_res   (w_scan)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_up_thr    <= UP_THRESHOLD_RST;
            r_down_thr  <= DOWN_THRESHOLD_RST;
            r_count     <= BACKEND_COUNT_RST;
            r_flags     <= '1;
            for (int i = 0; i < MAX_BACKENDS; i++) begin
                r_pass[i] <= '0;
                r_fail[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_update) begin
                r_pass[r_item.backend_index]  <= n_pass;
                r_fail[r_item.backend_index]  <= n_fail;
                r_flags[r_item.backend_index] <= n_flag;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_UP_THRESHOLD:   r_up_thr   <= i_cfg_data;
                    CFG_DOWN_THRESHOLD: r_down_thr <= i_cfg_data;
                    CFG_BACKEND_COUNT:  r_count    <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_item <= i_in;
        end
        r_res <= n_res;
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

endmodule
